// ===== sv/expired_id_range_set_macros.svh =====
// assertion macros for the expired id range set
`ifndef EXPIRED_ID_RANGE_SET_MACROS_SVH
`define EXPIRED_ID_RANGE_SET_MACROS_SVH

// checked only outside reset
`define EIRS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define EIRS_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/eirs_pkg.sv =====
// shared types and constants for the expired id range set
`default_nettype none
package eirs_pkg;

  localparam int unsigned MaxRangesDefault = 16;
  localparam int unsigned IdBitsDefault    = 31;

  localparam logic MODE_EXPIRE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // flags rippled from cell to cell, lowest index first
  typedef struct packed {
    logic hit;
    logic below;
    logic above;
    logic free_seen;
  } eirs_chain_t;

  // write-back control broadcast to every cell
  typedef struct packed {
    logic add;
    logic any_below;
    logic any_above;
  } eirs_upd_t;

endpackage
`default_nettype wire

// ===== sv/eirs_cell.sv =====
// one table entry: range storage, id compare and chain link
`default_nettype none
module eirs_cell #(
  parameter int unsigned ID_BITS = eirs_pkg::IdBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmp_en,
  input  logic [ID_BITS-1:0]   cmp_id,
  input  eirs_pkg::eirs_upd_t  upd,
  input  logic [ID_BITS-1:0]   upd_id,
  input  logic [ID_BITS-1:0]   merge_high,
  input  eirs_pkg::eirs_chain_t chain_in,
  input  logic [ID_BITS-1:0]   high_in,
  output eirs_pkg::eirs_chain_t chain_out,
  output logic [ID_BITS-1:0]   high_out
);
  import eirs_pkg::*;

  localparam logic [ID_BITS-1:0] IdMax = '1;

  logic               valid;
  logic [ID_BITS-1:0] lo;
  logic [ID_BITS-1:0] hi;
  logic               hit_f;
  logic               below_f;
  logic               above_f;
  logic               take_free;

  // compare against the incoming id as the request is taken
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      hit_f   <= valid && (lo <= cmp_id) && (cmp_id <= hi);
      below_f <= valid && (cmp_id != '0) && (hi == cmp_id - ID_BITS'(1));
      above_f <= valid && (cmp_id != IdMax) && (lo == cmp_id + ID_BITS'(1));
    end
  end

  assign take_free = !valid && !chain_in.free_seen;

  always_comb begin
    chain_out.hit       = chain_in.hit | hit_f;
    chain_out.below     = chain_in.below | below_f;
    chain_out.above     = chain_in.above | above_f;
    chain_out.free_seen = chain_in.free_seen | !valid;
  end

  // only one entry can border the id from above, so or-ing passes its high
  assign high_out = high_in | (above_f ? hi : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd.add) begin
      if (above_f && upd.any_below) begin
        valid <= 1'b0;
      end else if (take_free && !upd.any_below && !upd.any_above) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.add) begin
      if (below_f) begin
        hi <= upd.any_above ? merge_high : upd_id;
      end else if (above_f) begin
        if (!upd.any_below) begin
          lo <= upd_id;
        end
      end else if (take_free && !upd.any_below && !upd.any_above) begin
        lo <= upd_id;
        hi <= upd_id;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/expired_id_range_set.sv =====
// top level of the expired id range set
`default_nettype none
// Set of disjoint, non-adjacent closed ranges of expired job ids, held in a
// row of MAX_RANGES cells. An expire request (mode 0) adds job_id, extending
// or fusing neighboring ranges or taking the lowest free cell; table_full is
// set when none is free and the id is dropped. A query request (mode 1)
// reports is_expired. Every cell compares the id as the request is accepted
// and registers the flags; in the update state the hit, neighbor and free-cell
// flags ripple along the cell chain and the write-back lands on commit.
// The result sits in an output register, so the next request can be taken
// while it waits; a held result stalls the write-back of the following one.
module expired_id_range_set #(
  parameter int unsigned MAX_RANGES = eirs_pkg::MaxRangesDefault,
  parameter int unsigned ID_BITS    = eirs_pkg::IdBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [ID_BITS-1:0] job_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_expired,
  output logic               table_full
);
  import eirs_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic               state;
  logic               state_next;
  logic               accept;
  logic               commit;
  logic               mode_q;
  logic [ID_BITS-1:0] id_q;
  logic               full_now;
  eirs_upd_t          upd;

  eirs_chain_t        chain [MAX_RANGES+1];
  logic [ID_BITS-1:0] high_chain [MAX_RANGES+1];

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == ST_UPDATE) && (!out_valid || out_ready);

  assign chain[0]      = '0;
  assign high_chain[0] = '0;

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    eirs_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmp_en    (accept),
      .cmp_id    (job_id),
      .upd       (upd),
      .upd_id    (id_q),
      .merge_high(high_chain[MAX_RANGES]),
      .chain_in  (chain[i]),
      .high_in   (high_chain[i]),
      .chain_out (chain[i+1]),
      .high_out  (high_chain[i+1])
    );
  end

  always_comb begin
    upd.add       = commit && (mode_q == MODE_EXPIRE) && !chain[MAX_RANGES].hit;
    upd.any_below = chain[MAX_RANGES].below;
    upd.any_above = chain[MAX_RANGES].above;
  end

  assign full_now = (mode_q == MODE_EXPIRE) && !chain[MAX_RANGES].hit &&
                    !chain[MAX_RANGES].below && !chain[MAX_RANGES].above &&
                    !chain[MAX_RANGES].free_seen;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_UPDATE;
      ST_UPDATE: if (commit) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
      id_q   <= job_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      is_expired <= chain[MAX_RANGES].hit;
      table_full <= full_now;
    end
  end

`include "expired_id_range_set_macros.svh"

  `EIRS_ASSERT(a_commit_loads_result, commit |=> out_valid, "result not loaded")
  `EIRS_ASSERT(a_query_never_full, commit && mode_q == MODE_QUERY |=> !table_full, "full on query")
  `EIRS_ASSERT(a_hit_never_full, out_valid |-> !(is_expired && table_full), "hit and full together")
  `EIRS_ASSERT_RST(a_reset_clears, rst |=> !out_valid && in_ready, "reset left block busy")

endmodule
`default_nettype wire
